[rtl/wrpr_pkg.sv]
// Shared payload types, widths and register indexes for the weighted rigid point residual block.
`timescale 1ns / 1ps
`default_nettype none
package wrpr_pkg;

  // Input transaction payload, first field in the most significant bits.
  typedef struct packed {
    logic [31:0] quat_x;
    logic [31:0] quat_y;
    logic [31:0] quat_z;
    logic [31:0] quat_w;
    logic [31:0] trans_x;
    logic [31:0] trans_y;
    logic [31:0] trans_z;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
  } wrpr_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [31:0] res_x;
    logic [31:0] res_y;
    logic [31:0] res_z;
    logic        zero_quat;
  } wrpr_out_t;

  // Sum of four squared 32-bit magnitudes, padded to an even width.
  localparam int SQ_W   = 66;
  // Integer square root of that sum.
  localparam int ROOT_W = 33;
  // Magnitude of a normalized quaternion component (at most 2^30).
  localparam int UM_W   = 31;

  // Data that travels beside the square root pipeline.
  typedef struct packed {
    logic             zero;
    logic [3:0]       sgn;
    logic [3:0][31:0] qmag;
    logic [2:0][31:0] pnt;
    logic [2:0][31:0] trn;
  } wrpr_sq_side_t;

  // Data that travels beside the divider pipeline.
  typedef struct packed {
    logic             zero;
    logic [3:0]       sgn;
    logic [2:0][31:0] pnt;
    logic [2:0][31:0] trn;
  } wrpr_dv_side_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_TARGET_X = 3'd0;
  localparam logic [2:0] REG_TARGET_Y = 3'd1;
  localparam logic [2:0] REG_TARGET_Z = 3'd2;
  localparam logic [2:0] REG_WEIGHT_X = 3'd3;
  localparam logic [2:0] REG_WEIGHT_Y = 3'd4;
  localparam logic [2:0] REG_WEIGHT_Z = 3'd5;

  localparam logic [31:0] WEIGHT_ONE = 32'h0100_0000;

endpackage
`default_nettype wire

[rtl/wrpr_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module wrpr_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  logic [wrpr_pkg::SQ_W-1:0]    n_i,
  input  wrpr_pkg::wrpr_sq_side_t      side_i,
  output logic                         vld_o,
  output logic [wrpr_pkg::ROOT_W-1:0]  root_o,
  output wrpr_pkg::wrpr_sq_side_t      side_o
);
  import wrpr_pkg::*;

  localparam int NS = ROOT_W;
  localparam int RW = ROOT_W + 2;

  logic [NS-1:0]     vld_q;
  logic [SQ_W-1:0]   n_q    [NS];
  logic [SQ_W-1:0]   n_d    [NS];
  logic [SQ_W-1:0]   n_src  [NS];
  logic [RW-1:0]     rem_q  [NS];
  logic [RW-1:0]     rem_d  [NS];
  logic [RW-1:0]     rem_src[NS];
  logic [ROOT_W-1:0] root_q [NS];
  logic [ROOT_W-1:0] root_d [NS];
  logic [ROOT_W-1:0] root_src[NS];
  wrpr_sq_side_t     side_q [NS];

  // Stage inputs: the first stage starts from the radicand with an empty root.
  always_comb begin
    n_src[0]    = n_i;
    rem_src[0]  = '0;
    root_src[0] = '0;
    for (int k = 1; k < NS; k++) begin
      n_src[k]    = n_q[k-1];
      rem_src[k]  = rem_q[k-1];
      root_src[k] = root_q[k-1];
    end
  end

  // Each stage brings down two radicand bits and tries the next root bit.
  always_comb begin
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    for (int k = 0; k < NS; k++) begin
      cur   = {rem_src[k], n_src[k][SQ_W-1 -: 2]};
      trial = {2'b00, root_src[k], 2'b01};
      if (cur >= trial) begin
        rem_d[k]  = RW'(cur - trial);
        root_d[k] = {root_src[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_d[k]  = RW'(cur);
        root_d[k] = {root_src[k][ROOT_W-2:0], 1'b0};
      end
      n_d[k] = {n_src[k][SQ_W-3:0], 2'b00};
    end
  end

  // Valid bits advance with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], vld_i};
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < NS; k++) begin
        side_q[k] <= side_q[k-1];
      end
      for (int k = 0; k < NS; k++) begin
        n_q[k]    <= n_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
    end
  end

  assign vld_o  = vld_q[NS-1];
  assign root_o = root_q[NS-1];
  assign side_o = side_q[NS-1];

endmodule
`default_nettype wire

[rtl/wrpr_div.sv]
// Four-lane pipelined restoring divider that normalizes the quaternion components.
`timescale 1ns / 1ps
`default_nettype none
module wrpr_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 vld_i,
  input  logic [wrpr_pkg::ROOT_W-1:0]          root_i,
  input  logic [3:0][31:0]                     qmag_i,
  input  wrpr_pkg::wrpr_dv_side_t              side_i,
  output logic                                 vld_o,
  output logic [3:0][wrpr_pkg::UM_W-1:0]       umag_o,
  output wrpr_pkg::wrpr_dv_side_t              side_o
);
  import wrpr_pkg::*;

  // Numerator is magnitude * 2^30 plus half the divisor.
  localparam int NW = 32 + 30;
  localparam int ND = UM_W;
  localparam int LN = 4;

  // Front stage that forms the rounded numerators.
  logic              pv_q;
  logic [NW-1:0]     num_q [LN];
  logic [ROOT_W-1:0] pr_q;
  wrpr_dv_side_t     pside_q;

  logic [ND-1:0]     vld_q;
  logic [ROOT_W-1:0] r_q    [ND];
  logic [ROOT_W-1:0] r_src  [ND];
  wrpr_dv_side_t     side_q [ND];
  logic [ROOT_W-1:0] rem_q  [ND][LN];
  logic [ROOT_W-1:0] rem_d  [ND][LN];
  logic [ROOT_W-1:0] rem_src[ND][LN];
  logic [ND-1:0]     nb_q   [ND][LN];
  logic [ND-1:0]     nb_d   [ND][LN];
  logic [ND-1:0]     nb_src [ND][LN];
  logic [ND-1:0]     quo_q  [ND][LN];
  logic [ND-1:0]     quo_d  [ND][LN];
  logic [ND-1:0]     quo_src[ND][LN];

  // Stage inputs: the first stage takes the upper numerator bits as remainder.
  always_comb begin
    r_src[0] = pr_q;
    for (int l = 0; l < LN; l++) begin
      rem_src[0][l] = ROOT_W'(num_q[l][NW-1:ND]);
      nb_src[0][l]  = num_q[l][ND-1:0];
      quo_src[0][l] = '0;
    end
    for (int k = 1; k < ND; k++) begin
      r_src[k] = r_q[k-1];
      for (int l = 0; l < LN; l++) begin
        rem_src[k][l] = rem_q[k-1][l];
        nb_src[k][l]  = nb_q[k-1][l];
        quo_src[k][l] = quo_q[k-1][l];
      end
    end
  end

  // One quotient bit per stage and lane.
  always_comb begin
    logic [ROOT_W:0] cur;
    logic            ge;
    for (int k = 0; k < ND; k++) begin
      for (int l = 0; l < LN; l++) begin
        cur = {rem_src[k][l], nb_src[k][l][ND-1]};
        ge  = (cur >= {1'b0, r_src[k]});
        if (ge) begin
          rem_d[k][l] = ROOT_W'(cur - {1'b0, r_src[k]});
        end else begin
          rem_d[k][l] = ROOT_W'(cur);
        end
        quo_d[k][l] = {quo_src[k][l][ND-2:0], ge};
        nb_d[k][l]  = {nb_src[k][l][ND-2:0], 1'b0};
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      vld_q <= '0;
    end else if (en_i) begin
      pv_q  <= vld_i;
      vld_q <= {vld_q[ND-2:0], pv_q};
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q    <= root_i;
      pside_q <= side_i;
      for (int l = 0; l < LN; l++) begin
        num_q[l] <= {qmag_i[l], 30'd0} + NW'(root_i >> 1);
      end
      side_q[0] <= pside_q;
      for (int k = 1; k < ND; k++) begin
        side_q[k] <= side_q[k-1];
      end
      for (int k = 0; k < ND; k++) begin
        r_q[k] <= r_src[k];
        for (int l = 0; l < LN; l++) begin
          rem_q[k][l] <= rem_d[k][l];
          nb_q[k][l]  <= nb_d[k][l];
          quo_q[k][l] <= quo_d[k][l];
        end
      end
    end
  end

  assign vld_o  = vld_q[ND-1];
  assign side_o = side_q[ND-1];
  always_comb begin
    for (int l = 0; l < LN; l++) begin
      umag_o[l] = quo_q[ND-1][l];
    end
  end

endmodule
`default_nettype wire

[rtl/wrpr_xform.sv]
// Rotation, translation, target subtraction and weighting pipeline with the output register.
`timescale 1ns / 1ps
`default_nettype none
module wrpr_xform (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            vld_i,
  input  logic [3:0][wrpr_pkg::UM_W-1:0]  umag_i,
  input  wrpr_pkg::wrpr_dv_side_t         side_i,
  input  logic [2:0][31:0]                target_i,
  input  logic [2:0][31:0]                weight_i,
  output logic                            vld_o,
  output wrpr_pkg::wrpr_out_t             data_o
);
  import wrpr_pkg::*;

  localparam int EW = 42;
  localparam int CW = 40;
  localparam int NC = 7;

  // round(prod / 2^30) with the sign applied afterward.
  function automatic logic signed [CW-1:0] rnd_q30(input logic [67:0] prod, input logic neg);
    logic [68:0]    s;
    logic [CW-1:0]  m;
    s = {1'b0, prod} + 69'd536870912;
    m = CW'(s[68:30]);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  typedef struct packed {
    logic             zero;
    logic [2:0][31:0] pnt;
    logic [2:0][31:0] trn;
  } carry_t;

  // Pass-along fields, one entry per stage up to the rotation sum.
  logic [NC-1:0] v_q;
  carry_t        car_q [NC];

  // Stage 0: component magnitudes and signs.
  logic [3:0][UM_W-1:0] um0_q;
  logic [3:0]           us0_q;
  logic [2:0][31:0]     pm0_q;
  logic [2:0]           ps0_q;
  // Stage 1: first cross product partial products.
  logic [62:0]          pr1_q [3][2];
  logic                 ng1_q [3][2];
  logic [3:0][UM_W-1:0] um1_q, um2_q, um3_q;
  logic [3:0]           us1_q, us2_q, us3_q;
  // Stage 2: t = u x p.
  logic signed [CW-1:0] t2_q  [3];
  // Stage 3: magnitudes of t.
  logic [35:0]          tm3_q [3];
  logic [2:0]           ts3_q;
  // Stage 4: second cross product and scalar part products.
  logic [66:0]          pr4_q [3][3];
  logic                 ng4_q [3][3];
  // Stage 5: u x t and w * t.
  logic signed [CW-1:0] ct5_q [3];
  logic signed [CW-1:0] mw5_q [3];
  // Stage 6: rotated point.
  logic signed [EW-1:0] rot6_q [3];
  // Stage 7..9: error, its magnitude, weighted partial products.
  logic [2:0]           v789_q;
  logic signed [EW-1:0] e7_q  [3];
  logic [EW-2:0]        em8_q [3];
  logic [2:0]           es8_q, es9_q;
  logic [51:0]          pl9_q [3];
  logic [52:0]          ph9_q [3];
  logic [2:0]           z789_q;
  // Output register.
  logic                 out_vld_q;
  wrpr_out_t            out_q;
  logic [2:0][31:0]     res_d;

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q       <= '0;
      v789_q    <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      v_q       <= {v_q[NC-2:0], vld_i};
      v789_q    <= {v789_q[1:0], v_q[NC-1]};
      out_vld_q <= v789_q[2];
    end
  end

  // Final rounding and saturation of the weighted error.
  always_comb begin
    logic [75:0] full;
    logic [51:0] q;
    for (int i = 0; i < 3; i++) begin
      full = {3'd0, ph9_q[i], 20'd0} + 76'(pl9_q[i]) + 76'd8388608;
      q    = full[75:24];
      if (es9_q[i]) begin
        res_d[i] = (q > 52'h0_0000_8000_0000) ? 32'h8000_0000 : 32'(-q[32:0]);
      end else begin
        res_d[i] = (q > 52'h0_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      end
    end
  end

  // Arithmetic stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Stage 0: signed unit quaternion as sign and magnitude, point magnitudes.
      car_q[0].zero <= side_i.zero;
      car_q[0].pnt  <= side_i.pnt;
      car_q[0].trn  <= side_i.trn;
      for (int j = 0; j < 4; j++) begin
        um0_q[j] <= side_i.zero ? '0 : umag_i[j];
        us0_q[j] <= side_i.sgn[j];
      end
      for (int i = 0; i < 3; i++) begin
        ps0_q[i] <= side_i.pnt[i][31];
        pm0_q[i] <= side_i.pnt[i][31] ? 32'(-side_i.pnt[i]) : side_i.pnt[i];
      end
      for (int k = 1; k < NC; k++) begin
        car_q[k] <= car_q[k-1];
      end

      // Stage 1: products of u and p for t = u x p.
      for (int i = 0; i < 3; i++) begin
        pr1_q[i][0] <= um0_q[(i == 2) ? 0 : i + 1] * pm0_q[(i == 0) ? 2 : i - 1];
        pr1_q[i][1] <= um0_q[(i == 0) ? 2 : i - 1] * pm0_q[(i == 2) ? 0 : i + 1];
        ng1_q[i][0] <= us0_q[(i == 2) ? 0 : i + 1] ^ ps0_q[(i == 0) ? 2 : i - 1];
        ng1_q[i][1] <= us0_q[(i == 0) ? 2 : i - 1] ^ ps0_q[(i == 2) ? 0 : i + 1];
      end
      um1_q <= um0_q;
      us1_q <= us0_q;

      // Stage 2: rounded difference gives t.
      for (int i = 0; i < 3; i++) begin
        t2_q[i] <= rnd_q30(68'(pr1_q[i][0]), ng1_q[i][0])
                 - rnd_q30(68'(pr1_q[i][1]), ng1_q[i][1]);
      end
      um2_q <= um1_q;
      us2_q <= us1_q;

      // Stage 3: magnitude and sign of t.
      for (int i = 0; i < 3; i++) begin
        ts3_q[i] <= t2_q[i][CW-1];
        tm3_q[i] <= t2_q[i][CW-1] ? 36'(-t2_q[i]) : 36'(t2_q[i]);
      end
      um3_q <= um2_q;
      us3_q <= us2_q;

      // Stage 4: products for u x t and for w * t.
      for (int i = 0; i < 3; i++) begin
        pr4_q[i][0] <= um3_q[(i == 2) ? 0 : i + 1] * tm3_q[(i == 0) ? 2 : i - 1];
        pr4_q[i][1] <= um3_q[(i == 0) ? 2 : i - 1] * tm3_q[(i == 2) ? 0 : i + 1];
        pr4_q[i][2] <= um3_q[3] * tm3_q[i];
        ng4_q[i][0] <= us3_q[(i == 2) ? 0 : i + 1] ^ ts3_q[(i == 0) ? 2 : i - 1];
        ng4_q[i][1] <= us3_q[(i == 0) ? 2 : i - 1] ^ ts3_q[(i == 2) ? 0 : i + 1];
        ng4_q[i][2] <= us3_q[3] ^ ts3_q[i];
      end

      // Stage 5: rounded cross product and scalar term.
      for (int i = 0; i < 3; i++) begin
        ct5_q[i] <= rnd_q30(68'(pr4_q[i][0]), ng4_q[i][0])
                  - rnd_q30(68'(pr4_q[i][1]), ng4_q[i][1]);
        mw5_q[i] <= rnd_q30(68'(pr4_q[i][2]), ng4_q[i][2]);
      end

      // Stage 6: rotated point p + 2 w t + 2 u x t.
      for (int i = 0; i < 3; i++) begin
        rot6_q[i] <= EW'($signed(car_q[5].pnt[i])) + (EW'(mw5_q[i]) <<< 1)
                   + (EW'(ct5_q[i]) <<< 1);
      end

      // Stage 7: add translation, subtract target.
      for (int i = 0; i < 3; i++) begin
        e7_q[i] <= rot6_q[i] + EW'($signed(car_q[NC-1].trn[i]))
                 - EW'($signed(target_i[i]));
      end
      z789_q <= {z789_q[1:0], car_q[NC-1].zero};

      // Stage 8: sign and magnitude of the error.
      for (int i = 0; i < 3; i++) begin
        es8_q[i] <= e7_q[i][EW-1];
        em8_q[i] <= e7_q[i][EW-1] ? (EW-1)'(-e7_q[i]) : (EW-1)'(e7_q[i]);
      end

      // Stage 9: weight product split into two partial products.
      for (int i = 0; i < 3; i++) begin
        pl9_q[i] <= em8_q[i][19:0] * weight_i[i];
        ph9_q[i] <= em8_q[i][EW-2:20] * weight_i[i];
      end
      es9_q <= es8_q;

      // Output register.
      out_q.res_x     <= res_d[0];
      out_q.res_y     <= res_d[1];
      out_q.res_z     <= res_d[2];
      out_q.zero_quat <= z789_q[2];
    end
  end

  assign vld_o  = out_vld_q;
  assign data_o = out_q;

endmodule
`default_nettype wire

[rtl/weighted_rigid_point_residual_top.sv]
// Top level of the weighted rigid point residual pipeline.
//
// Input channel in_valid_i / in_stall_o / in_data_i carries a quaternion
// (Q2.30), a translation and a local point (Q16.16). Output channel
// out_valid_o / out_stall_i / out_data_o returns the three weighted residuals
// (Q16.16, saturated) and the zero quaternion flag. A transaction moves at a
// rising edge with valid high and stall low.
// Throughput is one transaction per cycle while the receiver does not stall.
// An accepted transaction passes 3 front stages (magnitudes, squares, sum), 33
// square root stages, 32 divider stages and 11 transform stages ending in the
// output register. The square root and the divider, one bit per stage, set the
// depth. The configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) writes the
// targets and weights; the user must write it only while no transaction is in
// flight, which the block does not enforce. Reset empties the pipeline, clears
// targets to 0 and sets weights to 1.0. When the receiver stalls a waiting
// result, the whole pipeline holds and in_stall_o rises in the same cycle;
// nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module weighted_rigid_point_residual_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  wrpr_pkg::wrpr_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output wrpr_pkg::wrpr_out_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);
  import wrpr_pkg::*;

  logic                 en;
  logic [2:0][31:0]     target_q;
  logic [2:0][31:0]     weight_q;

  logic                 s0_vld_q, s1_vld_q, s2_vld_q;
  logic [3:0][31:0]     qm0_q;
  logic [3:0]           qs0_q;
  logic [2:0][31:0]     p0_q, tr0_q;
  logic [3:0][63:0]     sq1_q;
  wrpr_sq_side_t        side1_q, side2_q;
  logic [SQ_W-1:0]      sum2_q;
  logic [31:0]          qin[4];

  logic                 sq_vld;
  logic [ROOT_W-1:0]    sq_root;
  wrpr_sq_side_t        sq_side;
  wrpr_dv_side_t        dv_side_in;
  logic                 dv_vld;
  logic [3:0][UM_W-1:0] dv_umag;
  wrpr_dv_side_t        dv_side;

  // The pipeline advances unless a finished result is held back.
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      weight_q <= {WEIGHT_ONE, WEIGHT_ONE, WEIGHT_ONE};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET_X: target_q[0] <= cfg_data_i;
        REG_TARGET_Y: target_q[1] <= cfg_data_i;
        REG_TARGET_Z: target_q[2] <= cfg_data_i;
        REG_WEIGHT_X: weight_q[0] <= cfg_data_i;
        REG_WEIGHT_Y: weight_q[1] <= cfg_data_i;
        REG_WEIGHT_Z: weight_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_valid_i;
      s1_vld_q <= s0_vld_q;
      s2_vld_q <= s1_vld_q;
    end
  end

  assign qin[0] = in_data_i.quat_x;
  assign qin[1] = in_data_i.quat_y;
  assign qin[2] = in_data_i.quat_z;
  assign qin[3] = in_data_i.quat_w;

  // Front end: magnitudes, squares, then the exact sum of squares.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        qs0_q[j] <= qin[j][31];
        qm0_q[j] <= qin[j][31] ? 32'(-qin[j]) : qin[j];
      end
      p0_q  <= {in_data_i.point_z, in_data_i.point_y, in_data_i.point_x};
      tr0_q <= {in_data_i.trans_z, in_data_i.trans_y, in_data_i.trans_x};

      for (int j = 0; j < 4; j++) begin
        sq1_q[j] <= qm0_q[j] * qm0_q[j];
      end
      // A quaternion with all four components zero is flagged here.
      side1_q.zero <= (qm0_q == '0);
      side1_q.sgn  <= qs0_q;
      side1_q.qmag <= qm0_q;
      side1_q.pnt  <= p0_q;
      side1_q.trn  <= tr0_q;

      sum2_q <= SQ_W'(sq1_q[0]) + SQ_W'(sq1_q[1]) + SQ_W'(sq1_q[2]) + SQ_W'(sq1_q[3]);
      side2_q <= side1_q;
    end
  end

  wrpr_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s2_vld_q),
    .n_i    (sum2_q),
    .side_i (side2_q),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  assign dv_side_in.zero = sq_side.zero;
  assign dv_side_in.sgn  = sq_side.sgn;
  assign dv_side_in.pnt  = sq_side.pnt;
  assign dv_side_in.trn  = sq_side.trn;

  wrpr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sq_vld),
    .root_i (sq_root),
    .qmag_i (sq_side.qmag),
    .side_i (dv_side_in),
    .vld_o  (dv_vld),
    .umag_o (dv_umag),
    .side_o (dv_side)
  );

  wrpr_xform u_xform (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (dv_vld),
    .umag_i   (dv_umag),
    .side_i   (dv_side),
    .target_i (target_q),
    .weight_i (weight_q),
    .vld_o    (out_valid_o),
    .data_o   (out_data_o)
  );

  // An empty output register never holds back the input.
  a_no_stall_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output register");

  // An accepted transaction enters the first stage.
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s0_vld_q)
    else $error("accepted transaction missing from first stage");

endmodule
`default_nettype wire
